[hdl/sfr_pkg.sv]
// shared types, codes and constants for the serial frame receiver and checker
// no dependencies; imported by every module under hdl
package sfr_pkg;

  // frame layout
  localparam int unsigned HdrLen = 4;
  localparam int unsigned QueueDepthDefault = 4;

  // configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_MAX_RX_LEN = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_TICKS = 2'd1;
  localparam logic [8:0] MAX_RX_LEN_RST = 9'd256;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

  // input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  // frame end result codes
  typedef enum logic [2:0] {
    RC_OK       = 3'd0,
    RC_OVERFLOW = 3'd1,
    RC_TIMEOUT  = 3'd2,
    RC_CHECKSUM = 3'd3,
    RC_SHORT    = 3'd4
  } result_code_t;

  // receive phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_PAY  = 5'b00100,
    PH_CKHI = 5'b01000,
    PH_CKLO = 5'b10000
  } phase_t;

  // input transaction
  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] opcode;
    logic [7:0] source;
    logic [7:0] status_byte;
    logic [7:0] frame_length;
    logic [2:0] result_code;
  } out_item_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic       is_tick;
    logic [7:0] rx_byte;
    logic       len_ovf;
    logic       len_short;
  } op_t;

  // queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

[hdl/sfr_front.sv]
// front end: accepts input transactions and classifies them for the back end
// depends on sfr_pkg
module sfr_front (
  input  sfr_pkg::in_item_t  in_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [8:0]         max_rx_len,
  input  sfr_pkg::q_status_t q_status,
  output logic               push,
  output sfr_pkg::op_t       push_op
);
  import sfr_pkg::*;

  logic [8:0] len_plus_one;

  // hold off the source while the queue is full
  assign in_stall = q_status.full;
  assign push = in_valid && !q_status.full;

  // precompute the length byte checks so the back end only selects
  assign len_plus_one = {1'b0, in_data.rx_byte} + 9'd1;

  always_comb begin
    push_op.is_tick   = (in_data.cmd == CMD_TICK);
    push_op.rx_byte   = in_data.rx_byte;
    push_op.len_ovf   = (len_plus_one > max_rx_len);
    push_op.len_short = (in_data.rx_byte < 8'(HdrLen));
  end

endmodule

[hdl/sfr_queue.sv]
// short queue of classified operations between front and back end
// depends on sfr_pkg
module sfr_queue #(
  parameter int unsigned DEPTH = sfr_pkg::QueueDepthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sfr_pkg::op_t       push_op,
  input  logic               pop,
  output sfr_pkg::op_t       pop_op,
  output sfr_pkg::q_status_t q_status
);
  import sfr_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  op_t             mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign q_status.empty = (count_r == '0);
  assign q_status.full  = (count_r == CntW'(DEPTH));
  assign pop_op = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  // checks
  property p_no_overrun;
    @(posedge clk) disable iff (!rst_n) q_status.full |-> !(push && !pop);
  endproperty
  a_no_overrun: assert property (p_no_overrun) else $error("queue overrun");

  property p_no_underrun;
    @(posedge clk) disable iff (!rst_n) q_status.empty |-> !pop;
  endproperty
  a_no_underrun: assert property (p_no_underrun) else $error("queue underrun");

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n) count_r <= CntW'(DEPTH);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("queue count out of range");

endmodule

[hdl/sfr_back.sv]
// back end: frame state machine, checksum check and output register
// depends on sfr_pkg
module sfr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        timeout_ticks,
  input  sfr_pkg::q_status_t q_status,
  input  sfr_pkg::op_t       pop_op,
  output logic               pop,
  output sfr_pkg::out_item_t out_data,
  output logic               out_valid,
  input  logic               out_stall
);
  import sfr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  frame_len_r, frame_len_nxt;
  logic [7:0]  byte_pos_r, byte_pos_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [7:0]  source_r, source_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  sum_hi_r, sum_hi_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  logic        res_valid;
  logic        res_end;
  logic [2:0]  res_code;
  logic [15:0] sum_add;
  logic [15:0] ticks_inc;
  logic [7:0]  pos_inc;
  logic [15:0] got_sum;

  // take the next operation whenever the output slot is free or draining
  assign pop = !q_status.empty && (!out_valid_r || !out_stall);

  assign sum_add   = sum_r + {8'd0, pop_op.rx_byte};
  assign ticks_inc = ticks_r + 16'd1;
  assign pos_inc   = byte_pos_r + 8'd1;
  assign got_sum   = {sum_hi_r, pop_op.rx_byte};

  // frame state machine
  always_comb begin
    phase_nxt     = phase_r;
    frame_len_nxt = frame_len_r;
    byte_pos_nxt  = byte_pos_r;
    sum_nxt       = sum_r;
    opcode_nxt    = opcode_r;
    source_nxt    = source_r;
    status_nxt    = status_r;
    sum_hi_nxt    = sum_hi_r;
    ticks_nxt     = ticks_r;
    res_valid     = 1'b0;
    res_end       = 1'b0;
    res_code      = RC_OK;
    if (pop) begin
      if (pop_op.is_tick) begin
        // ticks count only mid-frame
        if (phase_r != PH_IDLE) begin
          ticks_nxt = ticks_inc;
          if (ticks_inc >= timeout_ticks || ticks_inc == 16'd0) begin
            res_end  = 1'b1;
            res_code = RC_TIMEOUT;
          end
        end
      end else begin
        ticks_nxt = '0;
        unique case (phase_r)
          PH_IDLE: begin
            frame_len_nxt = pop_op.rx_byte;
            opcode_nxt    = '0;
            source_nxt    = '0;
            status_nxt    = '0;
            if (pop_op.len_ovf) begin
              res_end  = 1'b1;
              res_code = RC_OVERFLOW;
            end else if (pop_op.len_short) begin
              res_end  = 1'b1;
              res_code = RC_SHORT;
            end else begin
              sum_nxt      = {8'd0, pop_op.rx_byte};
              byte_pos_nxt = 8'd1;
              phase_nxt    = PH_HDR;
            end
          end
          PH_HDR: begin
            sum_nxt = sum_add;
            if (byte_pos_r == 8'd1) begin
              opcode_nxt = pop_op.rx_byte;
            end else if (byte_pos_r == 8'd2) begin
              source_nxt = pop_op.rx_byte;
            end else begin
              status_nxt = pop_op.rx_byte;
            end
            byte_pos_nxt = pos_inc;
            if (pos_inc >= 8'(HdrLen)) begin
              phase_nxt = (pos_inc >= frame_len_r) ? PH_CKHI : PH_PAY;
            end
          end
          PH_PAY: begin
            sum_nxt      = sum_add;
            res_valid    = 1'b1;
            byte_pos_nxt = pos_inc;
            if (pos_inc >= frame_len_r || pos_inc == 8'd0) begin
              phase_nxt = PH_CKHI;
            end
          end
          PH_CKHI: begin
            sum_hi_nxt = pop_op.rx_byte;
            phase_nxt  = PH_CKLO;
          end
          PH_CKLO: begin
            res_end  = 1'b1;
            res_code = (got_sum == (16'd0 - sum_r)) ? RC_OK : RC_CHECKSUM;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      // every frame end returns to idle
      if (res_end) begin
        res_valid    = 1'b1;
        phase_nxt    = PH_IDLE;
        byte_pos_nxt = '0;
        sum_nxt      = '0;
        sum_hi_nxt   = '0;
        ticks_nxt    = '0;
      end
    end
  end

  // result formatting into the output register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      if (res_end) begin
        out_nxt.kind         = KIND_FRAME_END;
        out_nxt.opcode       = opcode_nxt;
        out_nxt.source       = source_nxt;
        out_nxt.status_byte  = status_nxt;
        out_nxt.frame_length = frame_len_nxt;
        out_nxt.result_code  = res_code;
      end else begin
        out_nxt.kind          = KIND_PAYLOAD;
        out_nxt.payload_byte  = pop_op.rx_byte;
        out_nxt.payload_index = byte_pos_r - 8'(HdrLen);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      frame_len_r <= '0;
      byte_pos_r  <= '0;
      sum_r       <= '0;
      opcode_r    <= '0;
      source_r    <= '0;
      status_r    <= '0;
      sum_hi_r    <= '0;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      frame_len_r <= frame_len_nxt;
      byte_pos_r  <= byte_pos_nxt;
      sum_r       <= sum_nxt;
      opcode_r    <= opcode_nxt;
      source_r    <= source_nxt;
      status_r    <= status_nxt;
      sum_hi_r    <= sum_hi_nxt;
      ticks_r     <= ticks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  // checks
  property p_idle_clean;
    @(posedge clk) disable iff (!rst_n)
      (phase_r == PH_IDLE) |-> (ticks_r == 16'd0 && byte_pos_r == 8'd0 && sum_r == 16'd0);
  endproperty
  a_idle_clean: assert property (p_idle_clean) else $error("idle with stale frame state");

  property p_end_to_idle;
    @(posedge clk) disable iff (!rst_n) res_end |=> (phase_r == PH_IDLE && out_valid_r);
  endproperty
  a_end_to_idle: assert property (p_end_to_idle) else $error("frame end did not go idle");

  property p_pay_pos;
    @(posedge clk) disable iff (!rst_n)
      (phase_r == PH_PAY) |-> (byte_pos_r >= 8'(HdrLen) && byte_pos_r < frame_len_r);
  endproperty
  a_pay_pos: assert property (p_pay_pos) else $error("payload position out of frame");

endmodule

[hdl/serial_frame_receiver_checker.sv]
// top level of the serial frame receiver and checker
// depends on sfr_pkg, sfr_front, sfr_queue and sfr_back
//
// Takes one transaction per clock unless in_stall is high: a received byte or a
// time tick. Each frame is a length byte, three header bytes (opcode, source,
// status), length minus 4 payload bytes and a big-endian 16-bit checksum equal to
// the negated 16-bit sum of the length, header and payload bytes. Every payload
// byte is emitted as a result as it arrives, and one frame end result closes each
// frame with the header fields, the length and a code (ok, overflow, timeout,
// checksum mismatch, length below 4). Ticks while idle produce nothing. Sustained
// rate is one transaction per cycle unless stalled: the front end classifies and
// queues each transaction in the cycle it is accepted, and the back end frame
// state machine retires one per cycle into the output register. A transaction is
// registered in the queue, its result in the output register; the queue of
// QUEUE_DEPTH entries absorbs output stalls before in_stall rises. Configuration
// writes are always ready and must only be issued while no frame is in flight.
module serial_frame_receiver_checker #(
  parameter int unsigned QUEUE_DEPTH = sfr_pkg::QueueDepthDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sfr_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sfr_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sfr_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [sfr_pkg::CfgDataW-1:0]      cfg_wdata
);
  import sfr_pkg::*;

  logic [8:0]  max_rx_len_r;
  logic [15:0] timeout_ticks_r;
  logic        push;
  logic        pop;
  op_t         push_op;
  op_t         pop_op;
  q_status_t   q_status;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rx_len_r    <= MAX_RX_LEN_RST;
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_RX_LEN:    max_rx_len_r    <= cfg_wdata[8:0];
        CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front end
  sfr_front u_front (
    .in_data    (in_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .max_rx_len (max_rx_len_r),
    .q_status   (q_status),
    .push       (push),
    .push_op    (push_op)
  );

  // operation queue
  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_op  (push_op),
    .pop      (pop),
    .pop_op   (pop_op),
    .q_status (q_status)
  );

  // back end
  sfr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .timeout_ticks (timeout_ticks_r),
    .q_status      (q_status),
    .pop_op        (pop_op),
    .pop           (pop),
    .out_data      (out_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

endmodule

[bench/tb_serial_frame_receiver_checker.sv]
// self-checking testbench for serial_frame_receiver_checker
// depends on sfr_pkg and the rtl under hdl; reads nothing at run time
module tb_serial_frame_receiver_checker;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  localparam int QuietLimit = 1000;
  localparam int DrainCycles = 12;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct {
    in_item_t    it;
    int unsigned gap;
    int unsigned stall_max;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // receiver state mirror and its register copy
  logic [8:0]  lim_rx_len = MAX_RX_LEN_RST;
  logic [15:0] lim_ticks = TIMEOUT_TICKS_RST;
  phase_t      rx_phase = PH_IDLE;
  logic [7:0]  len_byte = '0;
  logic [7:0]  pos_cnt = '0;
  logic [15:0] sum_acc = '0;
  logic [7:0]  hold_opcode = '0;
  logic [7:0]  hold_source = '0;
  logic [7:0]  hold_status = '0;
  logic [7:0]  cksum_hi = '0;
  logic [15:0] tick_cnt = '0;

  out_item_t rx_results_due[$];
  pending_t  pending_inputs[$];
  pending_t  staged;
  bit          have_staged = 1'b0;
  bit          in_hold = 1'b0;
  int unsigned in_gap = 0;
  int unsigned gap_cap = 0;
  int unsigned stall_cap_gen = 0;
  int unsigned out_stall_cap = 0;
  int unsigned stall_wait = 0;

  int handshakes = 0;
  int seen_handshakes = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int queued_items = 0;
  int accepted_items = 0;
  int reg_writes = 0;
  int payload_seen = 0;
  int ends_seen = 0;
  int ends_by_code[5] = '{default: 0};

  serial_frame_receiver_checker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // frame end: emit header, length and code, then back to idle
  task automatic close_frame(result_code_t rc);
    out_item_t r;
    r = '0;
    r.kind = KIND_FRAME_END;
    r.opcode = hold_opcode;
    r.source = hold_source;
    r.status_byte = hold_status;
    r.frame_length = len_byte;
    r.result_code = rc;
    rx_results_due.push_back(r);
    rx_phase = PH_IDLE;
    pos_cnt = '0;
    sum_acc = '0;
    cksum_hi = '0;
    tick_cnt = '0;
  endtask

  // advance the receiver mirror by one accepted transaction
  task automatic receive_step(in_item_t t);
    out_item_t r;
    logic [15:0] want;
    if (t.cmd == CMD_TICK) begin
      if (rx_phase != PH_IDLE) begin
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= lim_ticks || tick_cnt == 16'd0) close_frame(RC_TIMEOUT);
      end
    end else begin
      tick_cnt = '0;
      case (rx_phase)
        PH_IDLE: begin
          len_byte = t.rx_byte;
          hold_opcode = '0;
          hold_source = '0;
          hold_status = '0;
          // overflow wins over the short length check
          if (int'(t.rx_byte) + 1 > int'(lim_rx_len)) close_frame(RC_OVERFLOW);
          else if (t.rx_byte < 8'(HdrLen)) close_frame(RC_SHORT);
          else begin
            sum_acc = {8'd0, t.rx_byte};
            pos_cnt = 8'd1;
            rx_phase = PH_HDR;
          end
        end
        PH_HDR: begin
          sum_acc = sum_acc + {8'd0, t.rx_byte};
          if (pos_cnt == 8'd1) hold_opcode = t.rx_byte;
          else if (pos_cnt == 8'd2) hold_source = t.rx_byte;
          else hold_status = t.rx_byte;
          pos_cnt = pos_cnt + 8'd1;
          if (pos_cnt >= 8'(HdrLen)) rx_phase = (pos_cnt >= len_byte) ? PH_CKHI : PH_PAY;
        end
        PH_PAY: begin
          sum_acc = sum_acc + {8'd0, t.rx_byte};
          r = '0;
          r.kind = KIND_PAYLOAD;
          r.payload_byte = t.rx_byte;
          r.payload_index = pos_cnt - 8'(HdrLen);
          rx_results_due.push_back(r);
          pos_cnt = pos_cnt + 8'd1;
          if (pos_cnt >= len_byte || pos_cnt == 8'd0) rx_phase = PH_CKHI;
        end
        PH_CKHI: begin
          cksum_hi = t.rx_byte;
          rx_phase = PH_CKLO;
        end
        default: begin
          want = 16'd0 - sum_acc;
          close_frame(({cksum_hi, t.rx_byte} == want) ? RC_OK : RC_CHECKSUM);
        end
      endcase
    end
  endtask

  task automatic log_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic cmp_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) log_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // input side: accept a transaction and update the mirror
  always @(posedge clk) begin : input_accept
    if (rst_n && in_valid && !in_stall) begin
      receive_step(in_data);
      in_hold = 1'b0;
      handshakes++;
      accepted_items++;
    end
  end

  // input driver, paced by the gap carried with each transaction
  always @(negedge clk) begin : input_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_hold) begin
      if (!have_staged && pending_inputs.size() != 0) begin
        staged = pending_inputs.pop_front();
        have_staged = 1'b1;
        in_gap = staged.gap;
        out_stall_cap = staged.stall_max;
      end
      if (have_staged && in_gap == 0) begin
        in_data <= staged.it;
        in_valid <= 1'b1;
        in_hold = 1'b1;
        have_staged = 1'b0;
      end else begin
        in_valid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end
    end
  end

  // result side: compare each transaction with the oldest one due
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      handshakes++;
      stall_wait = (out_stall_cap == 0) ? 0 : $urandom_range(0, out_stall_cap);
      if (rx_results_due.size() == 0) begin
        log_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = rx_results_due.pop_front();
        cmp_field("kind", 8'(out_data.kind), 8'(want.kind));
        cmp_field("payload_byte", out_data.payload_byte, want.payload_byte);
        cmp_field("payload_index", out_data.payload_index, want.payload_index);
        cmp_field("opcode", out_data.opcode, want.opcode);
        cmp_field("source", out_data.source, want.source);
        cmp_field("status_byte", out_data.status_byte, want.status_byte);
        cmp_field("frame_length", out_data.frame_length, want.frame_length);
        cmp_field("result_code", 8'(out_data.result_code), 8'(want.result_code));
        if (want.kind == KIND_PAYLOAD) payload_seen++;
        else begin
          ends_seen++;
          ends_by_code[want.result_code]++;
        end
      end
    end
  end

  // result stall driver
  always @(negedge clk) begin : result_stall
    if (stall_wait > 0) begin
      out_stall <= 1'b1;
      stall_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(negedge clk) begin : watchdog
    if (rst_n) begin
      if (handshakes != seen_handshakes) begin
        seen_handshakes = handshakes;
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("timeout after %0d idle cycles", quiet_cycles);
          $display("tb_serial_frame_receiver_checker: errors");
          $finish;
        end
      end
    end
  end

  function automatic int ticks_to_timeout();
    return (lim_ticks == 16'd0) ? 1 : int'(lim_ticks);
  endfunction

  task automatic push_item(logic c, logic [7:0] b);
    pending_t p;
    p.it.cmd = c;
    p.it.rx_byte = b;
    p.gap = (gap_cap == 0) ? 0 : $urandom_range(0, gap_cap);
    p.stall_max = stall_cap_gen;
    pending_inputs.push_back(p);
    queued_items++;
  endtask

  // queue the first keep bytes of a frame, with stray ticks that stay under the timeout
  task automatic push_frame(logic [7:0] len, logic [7:0] op, logic [7:0] src,
                            logic [7:0] st, bit bad_sum, int keep);
    logic [7:0] seq[$];
    logic [15:0] sum;
    int cap;
    seq = '{len, op, src, st};
    for (int i = HdrLen; i < int'(len); i++) seq.push_back(8'($urandom));
    sum = '0;
    foreach (seq[i]) sum = sum + {8'd0, seq[i]};
    sum = 16'd0 - sum;
    if (bad_sum) sum = sum ^ (16'd1 << $urandom_range(0, 15));
    seq.push_back(sum[15:8]);
    seq.push_back(sum[7:0]);
    cap = ticks_to_timeout();
    foreach (seq[i]) begin
      if (i < keep) begin
        if (i > 0 && cap > 1 && $urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, (cap > 4) ? 3 : cap - 1)) push_item(CMD_TICK, 8'($urandom));
        push_item(CMD_BYTE, seq[i]);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_inputs.size() != 0 || have_staged || in_hold) @(negedge clk);
  endtask

  // finish any open frame and let the block go quiet
  task automatic settle();
    wait_drained();
    while (rx_phase != PH_IDLE) begin
      push_item(CMD_BYTE, 8'($urandom));
      wait_drained();
    end
    while (rx_results_due.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    handshakes++;
    reg_writes++;
    if (idx == CFG_MAX_RX_LEN) lim_rx_len = data[8:0];
    else if (idx == CFG_TIMEOUT_TICKS) lim_ticks = data;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // unused upper bits of the limit write carry junk
  task automatic set_limits(int max_len, int ticks);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
    write_reg(CFG_MAX_RX_LEN, {7'($urandom), 9'(max_len)});
    write_reg(CFG_TIMEOUT_TICKS, 16'(ticks));
  endtask

  // mostly well-formed frames, plus short, oversized, timed out and noise traffic
  task automatic random_phase(int target);
    int start;
    int pick;
    int cap_len;
    int len;
    start = queued_items;
    cap_len = (lim_rx_len > 9'd256) ? 255 : int'(lim_rx_len) - 1;
    while (queued_items - start < target) begin
      gap_cap = ($urandom_range(0, 3) == 0) ? 0 : 5;
      stall_cap_gen = ($urandom_range(0, 3) == 0) ? 0 : 5;
      pick = $urandom_range(0, 99);
      if (cap_len < HdrLen) len = $urandom_range(HdrLen, 255);
      else if ($urandom_range(0, 19) == 0) len = $urandom_range(HdrLen, cap_len);
      else len = $urandom_range(HdrLen, (cap_len < 16) ? cap_len : 16);
      if (pick < 70) begin
        if (cap_len < HdrLen) push_item(CMD_BYTE, 8'(len));
        else push_frame(8'(len), 8'($urandom), 8'($urandom), 8'($urandom),
                        $urandom_range(0, 9) == 0, len + 2);
      end else if (pick < 80) begin
        if (lim_rx_len <= 9'd255 && $urandom_range(0, 1) == 1)
          push_item(CMD_BYTE, 8'($urandom_range(int'(lim_rx_len), 255)));
        else
          push_item(CMD_BYTE, 8'($urandom_range(0, HdrLen - 1)));
      end else if (pick < 90 && cap_len >= HdrLen) begin
        push_frame(8'(len), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0,
                   $urandom_range(1, len + 1));
        if (ticks_to_timeout() <= 64)
          repeat (ticks_to_timeout()) push_item(CMD_TICK, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) push_item(1'($urandom), 8'($urandom));
      end
    end
    settle();
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset limits: idle tick, short lengths, empty and one-byte frames
    gap_cap = 0;
    stall_cap_gen = 0;
    push_item(CMD_TICK, 8'hFF);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'h03);
    push_frame(8'd4, 8'hFF, 8'h00, 8'hA5, 1'b0, 6);
    gap_cap = 5;
    stall_cap_gen = 5;
    push_frame(8'd5, 8'h00, 8'hFF, 8'h5A, 1'b1, 7);
    settle();

    // smallest limit: lengths of 4 and more overflow, a length of 3 is short
    set_limits(4, 1);
    push_item(CMD_BYTE, 8'd4);
    push_item(CMD_BYTE, 8'hFF);
    push_item(CMD_BYTE, 8'd3);
    settle();

    // zero timeout acts as one; early end keeps only the opcode
    set_limits(256, 0);
    push_item(CMD_BYTE, 8'd6);
    push_item(CMD_BYTE, 8'h81);
    push_item(CMD_TICK, 8'h00);
    settle();

    set_limits(256, 1000);
    random_phase(105);
    set_limits(4, 65535);
    random_phase(105);
    set_limits(511, 0);
    random_phase(105);
    set_limits($urandom_range(5, 40), 3);
    random_phase(105);
    set_limits($urandom_range(4, 256), $urandom_range(1, 8));
    random_phase(105);
    set_limits(20, 1);
    random_phase(105);

    $display("covered %0d input transactions, %0d register writes, %0d payload bytes",
             accepted_items, reg_writes, payload_seen);
    $display("%0d frame ends: ok %0d, overflow %0d, timeout %0d, checksum %0d, short %0d",
             ends_seen, ends_by_code[RC_OK], ends_by_code[RC_OVERFLOW],
             ends_by_code[RC_TIMEOUT], ends_by_code[RC_CHECKSUM], ends_by_code[RC_SHORT]);
    if (mismatches == 0) begin
      $display("tb_serial_frame_receiver_checker: clean");
    end else begin
      $display("tb_serial_frame_receiver_checker: errors");
    end
    $finish;
  end

endmodule
